// ----- hdl/tde_pkg.sv -----
// Shared types, sizes and status codes for the trie dictionary engine.
// Has no dependencies; the engine and its checker both import it.
`default_nettype none
package tde_pkg;

	// Trie sizing.
	localparam int NODE_COUNT = 1024;
	localparam int SLOTS      = 48;
	localparam int WORD_LIMIT = 2048;

	localparam int NODE_W    = $clog2(NODE_COUNT);
	localparam int NCOUNT_W  = $clog2(NODE_COUNT + 1);
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int MEM_DEPTH = NODE_COUNT * SLOTS;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int WORD_W    = 11;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_BAD_CHAR   = 3'd2,
		ST_WORDS_FULL = 3'd3,
		ST_NODES_FULL = 3'd4
	} status_t;

	// One slot of a trie node: child link (zero means none) and word number.
	typedef struct packed {
		logic [NODE_W-1:0] child;
		logic [WORD_W-1:0] num;
		logic              valid;
	} entry_t;

	// Character classification result.
	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] idx;
	} slot_t;

	// Maps a character byte to its slot within a node.
	function automatic slot_t slot_of(input logic [7:0] c);
		slot_t s;
		s.ok  = 1'b1;
		s.idx = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.idx = SLOT_W'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.idx = SLOT_W'(c - 8'h61);
		end else begin
			case (c)
				8'h2E: s.idx = SLOT_W'(26); // '.'
				8'h28: s.idx = SLOT_W'(27); // '('
				8'h29: s.idx = SLOT_W'(28); // ')'
				8'h31: s.idx = SLOT_W'(29); // '1'
				8'h33: s.idx = SLOT_W'(30); // '3'
				8'h32: s.idx = SLOT_W'(31); // '2'
				8'h36: s.idx = SLOT_W'(32); // '6'
				8'h34: s.idx = SLOT_W'(33); // '4'
				8'h35: s.idx = SLOT_W'(34); // '5'
				8'h2C: s.idx = SLOT_W'(35); // ','
				8'h38: s.idx = SLOT_W'(36); // '8'
				8'h37: s.idx = SLOT_W'(37); // '7'
				8'h30: s.idx = SLOT_W'(38); // '0'
				8'h2D: s.idx = SLOT_W'(39); // '-'
				default: s.ok = 1'b0;
			endcase
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/trie_dictionary_engine.sv -----
// Trie dictionary engine: node memory, cursor walk, insert and lookup.
// Depends on tde_pkg for sizes, status codes and the character map.
`default_nettype none
// Words arrive one character per transaction with a find/add command and a
// last-character mark; exactly one result (status and word number) leaves per
// word, on its last character. After reset the block sweeps all NODE_COUNT x
// SLOTS entries of the node memory clear, one entry per cycle, and holds
// in_ready low meanwhile. For a character that reaches the node memory, the
// slot is read in the accept cycle and the entry is resolved and written back
// in the following cycle; no new character is taken until that write-back is
// done. A character of a word that has already failed, or a bad character, is
// absorbed without a node memory read. A result waits in an output register;
// non-final characters are still accepted while it waits.
module trie_dictionary_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [10:0]      word_id
);
	import tde_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_LOOK  = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   clr_q;
	logic [NODE_W-1:0]   cursor_q, cursor_d;
	logic [NCOUNT_W-1:0] nodes_used_q, nodes_used_d;
	logic [WORD_W-1:0]   words_used_q, words_used_d;
	logic                words_wrap_q, words_wrap_d;
	status_t             werr_q, werr_d;

	// Item held across the lookup cycle.
	logic                add_s1, last_s1;
	logic [ADDR_W-1:0]   addr_s1;

	// Output register.
	logic                out_valid_q;
	status_t             status_q;
	logic [WORD_W-1:0]   word_id_q;

	// Node memory.
	entry_t              mem [MEM_DEPTH];
	entry_t              rd_q;
	logic                mem_re, mem_we;
	logic [ADDR_W-1:0]   mem_raddr, mem_waddr;
	entry_t              mem_wdata;

	// Result produced this cycle.
	logic                emit;
	status_t             emit_status;
	logic [WORD_W-1:0]   emit_id;

	logic                accept, start;
	slot_t               slot;
	status_t             err_in;
	logic [ADDR_W-1:0]   addr_in;

	assign in_ready  = (state_q == S_IDLE) && (!last_char || !out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign word_id   = word_id_q;

	// Classify the incoming character and form its slot address.
	// The word count keeps growing past the table size through words that
	// start as a find, so a sticky flag remembers that the counter wrapped.
	always_comb begin
		slot    = slot_of(char_code);
		start   = (cursor_q == '0) && (werr_q == ST_OK);
		err_in  = werr_q;
		if (start && cmd &&
				(words_wrap_q || (words_used_q >= WORD_W'(WORD_LIMIT - 1)))) begin
			err_in = ST_WORDS_FULL;
		end
		if (err_in == ST_OK && !slot.ok) begin
			err_in = ST_BAD_CHAR;
		end
		addr_in = ADDR_W'(cursor_q) * ADDR_W'(SLOTS) + ADDR_W'(slot.idx);
	end

	// Control: clear sweep, accept, resolve the read entry, write back, emit results.
	always_comb begin
		state_d      = state_q;
		cursor_d     = cursor_q;
		nodes_used_d = nodes_used_q;
		words_used_d = words_used_q;
		words_wrap_d = words_wrap_q;
		werr_d       = werr_q;
		mem_re       = 1'b0;
		mem_raddr    = addr_in;
		mem_we       = 1'b0;
		mem_waddr    = addr_s1;
		mem_wdata    = rd_q;
		emit         = 1'b0;
		emit_status  = ST_OK;
		emit_id      = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (err_in != ST_OK) begin
						if (last_char) begin
							emit        = 1'b1;
							emit_status = err_in;
							cursor_d    = '0;
							werr_d      = ST_OK;
						end else begin
							werr_d = err_in;
						end
					end else begin
						mem_re  = 1'b1;
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
				if (!last_s1) begin
					if (rd_q.child == '0) begin
						if (!add_s1) begin
							werr_d = ST_NOT_FOUND;
						end else if (nodes_used_q >= NCOUNT_W'(NODE_COUNT)) begin
							werr_d = ST_NODES_FULL;
						end else begin
							mem_we          = 1'b1;
							mem_wdata.child = NODE_W'(nodes_used_q);
							cursor_d        = NODE_W'(nodes_used_q);
							nodes_used_d    = nodes_used_q + 1'b1;
						end
					end else begin
						cursor_d = rd_q.child;
					end
				end else begin
					emit     = 1'b1;
					cursor_d = '0;
					werr_d   = ST_OK;
					if (add_s1) begin
						mem_we          = 1'b1;
						mem_wdata.num   = words_used_q;
						mem_wdata.valid = 1'b1;
						emit_id         = words_used_q;
						words_used_d    = words_used_q + 1'b1;
						if (words_used_q == '1) begin
							words_wrap_d = 1'b1;
						end
					end else if (rd_q.valid) begin
						emit_id = rd_q.num;
					end else begin
						emit_status = ST_NOT_FOUND;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Node memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Item registers for the lookup cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			add_s1  <= cmd;
			last_s1 <= last_char;
			addr_s1 <= addr_in;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= emit_status;
			word_id_q <= emit_id;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			cursor_q     <= '0;
			nodes_used_q <= NCOUNT_W'(1);
			words_used_q <= '0;
			words_wrap_q <= 1'b0;
			werr_q       <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cursor_q     <= cursor_d;
			nodes_used_q <= nodes_used_d;
			words_used_q <= words_used_d;
			words_wrap_q <= words_wrap_d;
			werr_q       <= werr_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/tde_checker.sv -----
// Port-level checker for the trie dictionary engine, bound to the top level.
// Depends on tde_pkg for status codes.
`default_nettype none
module tde_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last_char,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [10:0] word_id
);
	import tde_pkg::*;

	// A result that is not taken holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(word_id))
		else $error("result changed while stalled");

	// Failed words carry word number zero.
	a_err_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> word_id == '0)
		else $error("nonzero word number on failed word");

	// Status is always a defined code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= 3'(ST_NODES_FULL)))
		else $error("undefined status code");

	// A character that does not end a word never causes a result.
	a_no_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_char && !out_valid |=> !out_valid)
		else $error("result after a non-final character");

endmodule

bind trie_dictionary_engine tde_checker u_tde_checker (.*);
`default_nettype wire
